@@ rtl/core/loop_current_pwm_scaler_defines.svh @@
// Assertion macros shared by the loop current scaler RTL.
`ifndef LOOP_CURRENT_PWM_SCALER_DEFINES_SVH
`define LOOP_CURRENT_PWM_SCALER_DEFINES_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define LCPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define LCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ rtl/core/lcps_pkg.sv @@
// Types and constants of the loop current PWM scaler.
package lcps_pkg;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_LOW     = 3'd1,
		ST_HIGH    = 3'd2,
		ST_DEFAULT = 3'd3,
		ST_SAT     = 3'd4
	} status_t;

	localparam int QW = 11;   // quotient bits above the 4 mA floor
	localparam int DW = 25;   // magnitude of the decoded span
	localparam int RW = 36;   // scaled remainder
	localparam int CW = 11;   // current in hundredths of a mA

	localparam logic [CW-1:0] CUR_MIN = 11'd400;
	localparam logic [CW-1:0] CUR_MAX = 11'd2000;

	// Word that travels beside the divider.
	typedef struct packed {
		logic               ch;
		logic signed [16:0] diff;
		status_t            st;
	} meta_t;

endpackage

@@ rtl/core/lcps_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module lcps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [lcps_pkg::RW-1:0]    in_rem,
	input  logic [lcps_pkg::DW-1:0]    in_den,
	input  lcps_pkg::meta_t            in_meta,
	output logic                       out_valid,
	output logic [lcps_pkg::QW-1:0]    out_q,
	output lcps_pkg::meta_t            out_meta
);
	import lcps_pkg::*;

	logic          valid_s [QW];
	logic [RW-1:0] rem_s   [QW];
	logic [DW-1:0] den_s   [QW];
	logic [QW-1:0] q_s     [QW];
	meta_t         meta_s  [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic          v_in;
		logic [RW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		meta_t         m_in;
		logic [RW-1:0] shifted;
		logic          ge;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = in_rem;
			assign d_in = in_den;
			assign q_in = '0;
			assign m_in = in_meta;
		end else begin : g_next
			assign v_in = valid_s[i-1];
			assign r_in = rem_s[i-1];
			assign d_in = den_s[i-1];
			assign q_in = q_s[i-1];
			assign m_in = meta_s[i-1];
		end

		// Stage i decides quotient bit QW-1-i.
		assign shifted = RW'(d_in) << (QW - 1 - i);
		assign ge      = (r_in >= shifted);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i]  <= ge ? (r_in - shifted) : r_in;
			den_s[i]  <= d_in;
			q_s[i]    <= q_in | (QW'(ge) << (QW - 1 - i));
			meta_s[i] <= m_in;
		end
	end

	assign out_valid = valid_s[QW-1];
	assign out_q     = q_s[QW-1];
	assign out_meta  = meta_s[QW-1];

endmodule

@@ rtl/core/loop_current_pwm_scaler.sv @@
// Top level of the loop current PWM scaler.
// A word is taken on every clock in which start is high; busy stays low. Each
// word gives one result, shown for one cycle with done high: decode stages
// turn the range ends and the value into a divider input, an eleven-stage
// divider forms the current, and further stages form the PWM compare count and
// the BCD digits. The receiver cannot stall, so nothing waits. The user must
// write the calibration registers through cfg_we, cfg_index and cfg_data only
// while no word is in flight; the block itself does not enforce this.
module loop_current_pwm_scaler #(
	parameter int COMPARE_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      start,
	output logic                      busy,
	input  logic                      channel_sel,
	input  logic signed [24:0]        measured_value,
	input  logic [31:0]               low_end_word,
	input  logic [31:0]               high_end_word,
	output logic                      done,
	output logic                      channel_out,
	output logic [10:0]               current_hundredths,
	output logic [13:0]               current_bcd,
	output logic [COMPARE_WIDTH-1:0]  compare_value,
	output lcps_pkg::status_t         status
);
	import lcps_pkg::*;
	`include "loop_current_pwm_scaler_defines.svh"

	localparam logic [32:0] CMAX = (33'd1 << COMPARE_WIDTH) - 33'd1;

	logic [15:0] cal_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) cal_q[i] <= '0;
		end else if (cfg_we) begin
			cal_q[cfg_index] <= cfg_data;
		end
	end

	assign busy = 1'b0;

	// Stage 1: decode both BCD range ends to thousandths.
	logic [17:0] lo_mag;
	logic [24:0] hi_mag;
	always_comb begin
		lo_mag = 18'(low_end_word[11:8] * 18'd10000) + 18'(low_end_word[7:4] * 18'd1000)
			+ 18'(low_end_word[3:0] * 18'd100);
		hi_mag = 25'(high_end_word[23:20] * 25'd1000000)
			+ 25'(high_end_word[19:16] * 25'd100000)
			+ 25'(high_end_word[15:12] * 25'd10000)
			+ 25'(high_end_word[11:8] * 25'd1000)
			+ 25'(high_end_word[7:4] * 25'd100)
			+ 25'(high_end_word[3:0] * 25'd10);
	end

	logic               v_s1, ch_s1;
	logic signed [24:0] m_s1;
	logic signed [18:0] lo_s1;
	logic signed [25:0] hi_s1;
	logic signed [16:0] diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		ch_s1   <= channel_sel;
		m_s1    <= measured_value;
		lo_s1   <= low_end_word[31] ? -$signed({1'b0, lo_mag}) : $signed({1'b0, lo_mag});
		hi_s1   <= high_end_word[31] ? -$signed({1'b0, hi_mag}) : $signed({1'b0, hi_mag});
		diff_s1 <= channel_sel ? ($signed({1'b0, cal_q[3]}) - $signed({1'b0, cal_q[2]}))
		                       : ($signed({1'b0, cal_q[1]}) - $signed({1'b0, cal_q[0]}));
	end

	// Stage 2: span and offset from the low end.
	logic               v_s2, ch_s2;
	logic signed [25:0] span_s2, dml_s2;
	logic signed [16:0] diff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		ch_s2   <= ch_s1;
		span_s2 <= hi_s1 - 26'(lo_s1);
		dml_s2  <= 26'(m_s1) - 26'(lo_s1);
		diff_s2 <= diff_s1;
	end

	// Stage 3: make the divisor positive and scale the offset by 1600.
	// The result is the numerator with the 4 mA part already taken out.
	logic signed [35:0] scaled;
	assign scaled = (36'(dml_s2) <<< 10) + (36'(dml_s2) <<< 9) + (36'(dml_s2) <<< 6);

	logic               v_s3, ch_s3, zero_s3;
	logic [DW-1:0]      den_s3;
	logic signed [35:0] r_s3;
	logic signed [16:0] diff_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		ch_s3   <= ch_s2;
		zero_s3 <= (span_s2 == '0);
		den_s3  <= span_s2[25] ? DW'(-span_s2) : DW'(span_s2);
		r_s3    <= span_s2[25] ? -scaled : scaled;
		diff_s3 <= diff_s2;
	end

	// Stage 4: clamp decisions. Above 20 mA exactly when r >= 1601 * den.
	logic [RW-1:0] lim;
	assign lim = (RW'(den_s3) << 10) + (RW'(den_s3) << 9) + (RW'(den_s3) << 6) + RW'(den_s3);

	logic          v_s4;
	logic [RW-1:0] r_s4;
	logic [DW-1:0] den_s4;
	meta_t         meta_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		r_s4          <= r_s3;
		den_s4        <= den_s3;
		meta_s4.ch    <= ch_s3;
		meta_s4.diff  <= diff_s3;
		if (zero_s3)                  meta_s4.st <= ST_DEFAULT;
		else if (r_s3[35])            meta_s4.st <= ST_LOW;
		else if ($unsigned(r_s3) >= lim) meta_s4.st <= ST_HIGH;
		else                          meta_s4.st <= ST_OK;
	end

	logic          v_dv;
	logic [QW-1:0] q_dv;
	meta_t         meta_dv;

	lcps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_rem    (r_s4),
		.in_den    (den_s4),
		.in_meta   (meta_s4),
		.out_valid (v_dv),
		.out_q     (q_dv),
		.out_meta  (meta_dv)
	);

	// Stage 5: clamped current.
	logic               v_s5, ch_s5;
	logic [CW-1:0]      cur_s5;
	status_t            st_s5;
	logic signed [16:0] diff_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_dv;
	end

	always_ff @(posedge clk) begin
		ch_s5   <= meta_dv.ch;
		st_s5   <= meta_dv.st;
		diff_s5 <= meta_dv.diff;
		case (meta_dv.st)
			ST_HIGH: cur_s5 <= CUR_MAX;
			ST_OK:   cur_s5 <= CUR_MIN + q_dv;
			default: cur_s5 <= CUR_MIN;
		endcase
	end

	// Stage 6: span product; hundreds of the current by reciprocal.
	logic               v_s6, ch_s6;
	logic [CW-1:0]      cur_s6;
	status_t            st_s6;
	logic signed [28:0] prod_s6;
	logic [4:0]         h_s6;
	logic [23:0]        hmul;
	assign hmul = 24'(cur_s5) * 24'd5243;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		ch_s6   <= ch_s5;
		cur_s6  <= cur_s5;
		st_s6   <= st_s5;
		prod_s6 <= $signed({18'd0, cur_s5}) * 29'(diff_s5);
		h_s6    <= hmul[23:19];
	end

	// Stage 7: divide by 1600 as a shift by 6 and a reciprocal of 25.
	logic               v_s7, ch_s7, neg_s7;
	logic [1:0]         thou_s7;
	logic [CW-1:0]      cur_s7;
	status_t            st_s7;
	logic [43:0]        qm_s7;
	logic [6:0]         rem_s7;
	logic [3:0]         hund_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else         v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		ch_s7   <= ch_s6;
		cur_s7  <= cur_s6;
		st_s7   <= st_s6;
		neg_s7  <= prod_s6[28];
		qm_s7   <= 44'(prod_s6[26:6]) * 44'd5368710;
		rem_s7  <= 7'(cur_s6 - 11'(h_s6 * 7'd100));
		if (h_s6 >= 5'd20) begin
			thou_s7 <= 2'd2;
			hund_s7 <= 4'(h_s6 - 5'd20);
		end else if (h_s6 >= 5'd10) begin
			thou_s7 <= 2'd1;
			hund_s7 <= 4'(h_s6 - 5'd10);
		end else begin
			thou_s7 <= 2'd0;
			hund_s7 <= 4'(h_s6);
		end
	end

	// Output stage: saturation, tens and ones digits.
	logic [16:0] cmp_raw;
	logic [14:0] tmul;
	logic [3:0]  tens;
	logic        over;
	assign cmp_raw = qm_s7[43:27];
	assign tmul    = 15'(rem_s7) * 15'd205;
	assign tens    = tmul[14:11];
	assign over    = (33'(cmp_raw) > CMAX);

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= v_s7;
	end

	logic                     ch_q;
	logic [CW-1:0]            cur_q;
	logic [13:0]              bcd_q;
	logic [COMPARE_WIDTH-1:0] cmp_q;
	status_t                  st_q;

	always_ff @(posedge clk) begin
		ch_q  <= ch_s7;
		cur_q <= cur_s7;
		bcd_q <= {thou_s7, hund_s7, tens, 4'(rem_s7 - 7'(tens * 4'd10))};
		if (neg_s7) begin
			cmp_q <= '0;
			st_q  <= ST_SAT;
		end else if (over) begin
			cmp_q <= CMAX[COMPARE_WIDTH-1:0];
			st_q  <= ST_SAT;
		end else begin
			cmp_q <= COMPARE_WIDTH'(cmp_raw);
			st_q  <= st_s7;
		end
	end

	assign done               = done_q;
	assign channel_out        = ch_q;
	assign current_hundredths = cur_q;
	assign current_bcd        = bcd_q;
	assign compare_value      = cmp_q;
	assign status             = st_q;

	`LCPS_ASSERT_NOW(a_cur_range, done, (cur_q >= CUR_MIN) && (cur_q <= CUR_MAX), "current out of range")
	`LCPS_ASSERT_NOW(a_default_min, done && (st_q == ST_DEFAULT), cur_q == CUR_MIN, "default range without 4 mA")
	`LCPS_ASSERT_NEXT(a_last_stage, v_s7, done, "result strobe lost at the output stage")

endmodule
